>>> sv/rqds_pkg.sv
// Package for the ready queue with delta sleep list.
// Holds request and status codes and the controller/datapath bundles.
// No dependencies.
package rqds_pkg;

    localparam int ID_W    = 4;
    localparam int TICKS_W = 32;
    localparam int REQ_W   = 3;
    localparam int ST_W    = 2;

    localparam logic [REQ_W-1:0] REQ_PUT_TAIL  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUT_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GET       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SLEEP     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_WAKE      = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture the input item, clear result
        logic exec;      // request work (puts, sleep full check, tick)
        logic walk;      // advance the sleep insert cursor
        logic ins;       // insert into the sleep list at the cursor
        logic take;      // take the ready head
        logic wake;      // move one expired sleep head to ready
        logic finish;    // load the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             skip_ins;   // duplicate id or full sleep list
        logic             walk_done;  // cursor reached its place
        logic             wake_more;  // sleep head expired
        logic             ready_full;
        logic             out_busy;   // output register held and not taken
    } sts_t;

endpackage

>>> sv/ready_queue_with_delta_sleep_list.sv
// Top level of the ready queue with delta sleep list.
// Depends on rqds_pkg, rqds_ctrl and rqds_dp.
//
//   channel | direction | contents
//   s_*     | in        | tuser: req_type[2:0]; tdata: thread_id[3:0], sleep_ticks[35:4]
//   m_*     | out       | tdata: out_thread, out_valid, woken_count, ready_count,
//           |           |        sleeping_count, status (lowest bit first)
//
// One item at a time: put, tick and unused codes are decoded, run and finished; get
// takes the ready head; sleep walks the insert cursor to its place, inserts, then also
// takes the ready head (walk and insert are skipped when the insert is dropped); wake
// moves expired sleep heads to ready one by one until none is left or ready is full.
// Reset clears both lengths and all queued flags; list contents need none.
// A result held in the output register stalls only the final step.
module ready_queue_with_delta_sleep_list #(
    parameter int NUM_THREADS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // thread_id, sleep_ticks, zero fill
    input  logic [2:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // out_thread, out_valid, woken_count,
                                   // ready_count, sleeping_count, status, zero fill
);
    rqds_pkg::cmd_t cmd;
    rqds_pkg::sts_t sts;

    rqds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rqds_dp #(
        .NUM_THREADS (NUM_THREADS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (s_tuser),
        .in_tid    (s_tdata[3:0]),
        .in_ticks  (s_tdata[35:4]),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    // checks that a taken thread comes with ok status
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[21:20] == rqds_pkg::ST_OK)
        else $error("taken thread with nonzero status");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

endmodule

>>> sv/rqds_dp.sv
// Datapath: ready queue, delta sleep list, queued flags and output register.
// Depends on rqds_pkg.
module rqds_dp #(
    parameter int NUM_THREADS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rqds_pkg::cmd_t                cmd,
    output rqds_pkg::sts_t                sts,
    input  logic [rqds_pkg::REQ_W-1:0]    in_req,
    input  logic [rqds_pkg::ID_W-1:0]     in_tid,
    input  logic [rqds_pkg::TICKS_W-1:0]  in_ticks,
    output logic [23:0]                   out_data,
    output logic                          out_valid,
    input  logic                          out_ready
);
    localparam int IW = $clog2(NUM_THREADS);
    localparam int CW = $clog2(NUM_THREADS + 1);
    localparam int NID = 1 << rqds_pkg::ID_W;

    logic [rqds_pkg::ID_W-1:0]    rq_reg [NUM_THREADS];
    logic [rqds_pkg::ID_W-1:0]    sq_reg [NUM_THREADS];
    logic [rqds_pkg::TICKS_W-1:0] sd_reg [NUM_THREADS];
    logic [CW-1:0] rlen_reg, slen_reg, pos_reg, woken_reg;
    logic [NID-1:0] queued_reg;
    logic [rqds_pkg::REQ_W-1:0]   req_reg;
    logic [rqds_pkg::ID_W-1:0]    tid_reg, tk_reg;
    logic [rqds_pkg::TICKS_W-1:0] ticks_reg;
    logic [rqds_pkg::TICKS_W:0]   total_reg;
    logic [rqds_pkg::ST_W-1:0]    st_reg;
    logic vl_reg, ov_reg;
    logic [23:0] od_reg;

    logic dup, rfull, sfull, rempty;
    logic [rqds_pkg::TICKS_W:0] sum;
    logic [rqds_pkg::TICKS_W-1:0] rel;
    logic put_ok;

    // decode occupancy and duplicate checks
    assign dup    = (32'(tid_reg) >= NUM_THREADS) || queued_reg[tid_reg];
    assign rfull  = (rlen_reg == CW'(NUM_THREADS));
    assign sfull  = (slen_reg == CW'(NUM_THREADS));
    assign rempty = (rlen_reg == '0);
    assign sum    = total_reg + {1'b0, sd_reg[pos_reg[IW-1:0]]};
    assign rel    = ticks_reg - total_reg[rqds_pkg::TICKS_W-1:0];
    assign put_ok = !dup && !rfull;

    always_comb
    begin
        sts.req        = req_reg;
        sts.skip_ins   = dup || sfull;
        sts.walk_done  = (pos_reg == slen_reg) || (sum > {1'b0, ticks_reg});
        sts.wake_more  = (slen_reg != '0) && (sd_reg[0] == '0);
        sts.ready_full = rfull;
        sts.out_busy   = ov_reg && !out_ready;
    end

    // list storage: per-entry shift, insert and append
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            if (cmd.exec && req_reg == rqds_pkg::REQ_PUT_TAIL && put_ok
                && CW'(i) == rlen_reg)
            begin
                rq_reg[i] <= tid_reg;
            end
            else if (cmd.exec && req_reg == rqds_pkg::REQ_PUT_FRONT && put_ok)
            begin
                rq_reg[i] <= (i == 0) ? tid_reg : rq_reg[(i == 0) ? 0 : i - 1];
            end
            else if (cmd.take && !rempty && i < NUM_THREADS - 1)
            begin
                rq_reg[i] <= rq_reg[(i < NUM_THREADS - 1) ? i + 1 : i];
            end
            else if (cmd.wake && sts.wake_more && !rfull && CW'(i) == rlen_reg)
            begin
                rq_reg[i] <= sq_reg[0];
            end

            if (cmd.ins)
            begin
                if (CW'(i) == pos_reg)
                begin
                    sq_reg[i] <= tid_reg;
                    sd_reg[i] <= rel;
                end
                else if (CW'(i) > pos_reg && CW'(i) <= slen_reg)
                begin
                    sq_reg[i] <= sq_reg[(i == 0) ? 0 : i - 1];
                    if (CW'(i) == pos_reg + CW'(1))
                        sd_reg[i] <= sd_reg[(i == 0) ? 0 : i - 1] - rel;
                    else
                        sd_reg[i] <= sd_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.wake && sts.wake_more && !rfull && i < NUM_THREADS - 1)
            begin
                sq_reg[i] <= sq_reg[(i < NUM_THREADS - 1) ? i + 1 : i];
                sd_reg[i] <= sd_reg[(i < NUM_THREADS - 1) ? i + 1 : i];
            end
            else if (cmd.exec && req_reg == rqds_pkg::REQ_TICK && i == 0
                     && slen_reg != '0 && sd_reg[0] != '0)
            begin
                sd_reg[i] <= sd_reg[i] - 1'b1;
            end
        end

        // capture the item
        if (cmd.load)
        begin
            req_reg   <= in_req;
            tid_reg   <= in_tid;
            ticks_reg <= in_ticks;
        end
    end

    // control state: lengths, flags, cursor, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rlen_reg   <= '0;
            slen_reg   <= '0;
            queued_reg <= '0;
            pos_reg    <= '0;
            total_reg  <= '0;
            woken_reg  <= '0;
            st_reg     <= rqds_pkg::ST_OK;
            tk_reg     <= '0;
            vl_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            od_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg   <= '0;
                total_reg <= '0;
                woken_reg <= '0;
                st_reg    <= rqds_pkg::ST_OK;
                tk_reg    <= '0;
                vl_reg    <= 1'b0;
            end

            if (cmd.exec)
            begin
                unique case (req_reg)
                    rqds_pkg::REQ_PUT_TAIL, rqds_pkg::REQ_PUT_FRONT:
                    begin
                        if (!dup && rfull)
                            st_reg <= rqds_pkg::ST_FULL;
                        else if (put_ok)
                        begin
                            rlen_reg            <= rlen_reg + 1'b1;
                            queued_reg[tid_reg] <= 1'b1;
                        end
                    end
                    rqds_pkg::REQ_SLEEP:
                    begin
                        if (!dup && sfull)
                            st_reg <= rqds_pkg::ST_FULL;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // advance the insert cursor
            if (cmd.walk)
            begin
                pos_reg   <= pos_reg + 1'b1;
                total_reg <= sum;
            end

            if (cmd.ins)
            begin
                slen_reg            <= slen_reg + 1'b1;
                queued_reg[tid_reg] <= 1'b1;
            end

            // take the ready head
            if (cmd.take)
            begin
                if (!rempty)
                begin
                    tk_reg                <= rq_reg[0];
                    vl_reg                <= 1'b1;
                    rlen_reg              <= rlen_reg - 1'b1;
                    queued_reg[rq_reg[0]] <= 1'b0;
                end
                else if (st_reg == rqds_pkg::ST_OK)
                    st_reg <= rqds_pkg::ST_EMPTY;
            end

            // move one expired sleeper
            if (cmd.wake && sts.wake_more)
            begin
                if (rfull)
                    st_reg <= rqds_pkg::ST_FULL;
                else
                begin
                    slen_reg  <= slen_reg - 1'b1;
                    rlen_reg  <= rlen_reg + 1'b1;
                    woken_reg <= woken_reg + 1'b1;
                end
            end

            // output register
            if (cmd.finish)
            begin
                ov_reg <= 1'b1;
                od_reg <= {2'b00, st_reg, 5'(slen_reg), 5'(rlen_reg), 5'(woken_reg),
                           vl_reg, tk_reg};
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_data  = od_reg;
    assign out_valid = ov_reg;

endmodule

>>> sv/rqds_ctrl.sv
// Controller: sequences one request through the datapath.
// Depends on rqds_pkg.
module rqds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rqds_pkg::sts_t  sts,
    output rqds_pkg::cmd_t  cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_TAKE = 3'd4;
    localparam logic [2:0] S_WAKE = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                priority case (sts.req)
                    rqds_pkg::REQ_GET:
                        state_next = S_TAKE;
                    rqds_pkg::REQ_SLEEP:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = sts.skip_ins ? S_TAKE : S_WALK;
                    end
                    rqds_pkg::REQ_WAKE:
                        state_next = S_WAKE;
                    default:
                    begin
                        cmd.exec   = 1'b1;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_WALK:
            begin
                if (sts.walk_done)
                    state_next = S_INS;
                else
                    cmd.walk = 1'b1;
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_FIN;
            end
            S_WAKE:
            begin
                cmd.wake = 1'b1;
                if (!sts.wake_more || sts.ready_full)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
